>>> hw/rtl/cflr_pkg.sv
// Package for the framed line receiver: word types, phase codes, status codes,
// character constants and the small per-byte helper functions.
// Depends on nothing; used by every module of the receiver.
`default_nettype none

package cflr_pkg;

	// Input word: one received character or a timeout event.
	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_word_t;

	// Result word: either a payload character or a frame verdict.
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [31:0] sequence_res;
		logic [7:0]  channel;
		logic [9:0]  payload_length;
	} out_word_t;

	// Parser phase, one-hot.
	typedef enum logic [6:0] {
		PH_LEAD    = 7'b0000001,
		PH_SEQ     = 7'b0000010,
		PH_CHAN    = 7'b0000100,
		PH_LEN     = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_HEX     = 7'b0100000,
		PH_ERR     = 7'b1000000
	} phase_t;

	// Frame facts the verdict logic looks at, apart from the line counters.
	typedef struct packed {
		phase_t          phase;
		logic [31:0]     len_acc;
		logic [15:0]     crc;
		logic [3:0][7:0] hex_text;
		logic [2:0]      hex_count;
		logic            hex_ok;
	} frame_info_t;

	// Input modes and result kinds.
	localparam logic MODE_BYTE    = 1'b0;
	localparam logic MODE_TIMEOUT = 1'b1;
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_FORMAT   = 3'd2;
	localparam logic [2:0] ST_LENGTH   = 3'd3;
	localparam logic [2:0] ST_CRC      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	// Field parser sub-states.
	localparam logic [1:0] SUB_START = 2'd0;
	localparam logic [1:0] SUB_SIGN  = 2'd1;
	localparam logic [1:0] SUB_DIGIT = 2'd2;
	localparam logic [1:0] SUB_DONE  = 2'd3;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_XL    = 8'h78;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// Numeric constants.
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [32:0] NUM_SAT   = 33'h1_0000_0000;
	localparam logic [10:0] CAP_RESET = 11'd1024;
	localparam logic [10:0] CAP_MIN   = 11'd2;

	// White space: space, TAB, LF, VT, FF, CR.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Hex digit decode: bit 4 says the character is a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// One byte of CRC16-CCITT, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// Decimal accumulate of one digit, saturating at 2^32.
	function automatic logic [32:0] num_step(input logic [32:0] num, input logic [3:0] d);
		logic [36:0] p;
		p = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + {33'd0, d};
		return (p > {4'd0, NUM_SAT}) ? NUM_SAT : p[32:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cflr_judge.sv
// Frame verdict logic: decodes the four hex characters and ranks the checks.
// Depends on cflr_pkg.
`default_nettype none

module cflr_judge #(
	parameter int LINE_MAX = 1024,
	localparam int LC_W = $clog2(LINE_MAX)
) (
	input  wire logic [10:0]          capacity,
	input  wire logic                 timeout,
	input  wire logic                 cut,
	input  wire cflr_pkg::frame_info_t info,
	input  wire logic [LC_W-1:0]      line_count,
	input  wire logic [LC_W-1:0]      pending_cr,
	input  wire logic [LC_W-1:0]      payload_count,
	output logic [2:0]                status
);

	logic [15:0] hex_value;
	logic [31:0] count_ext;
	logic        hex_short;

	// Decode the hex field: white space, sign, 0x prefix, then hex digits.
	always_comb begin
		logic [2:0]  i;
		logic        neg;
		logic [15:0] v;
		logic [4:0]  hv;
		i   = 3'd0;
		neg = 1'b0;
		v   = 16'd0;
		for (int k = 0; k < 4; k++) begin
			if (i == 3'(k) && cflr_pkg::is_ws(info.hex_text[k])) begin
				i = 3'(k + 1);
			end
		end
		if (i < 3'd4) begin
			if (info.hex_text[i[1:0]] == cflr_pkg::CH_PLUS ||
			    info.hex_text[i[1:0]] == cflr_pkg::CH_MINUS) begin
				neg = (info.hex_text[i[1:0]] == cflr_pkg::CH_MINUS);
				i   = i + 3'd1;
			end
		end
		if (i < 3'd3) begin
			if (info.hex_text[i[1:0]] == cflr_pkg::CH_ZERO &&
			    (info.hex_text[i[1:0] + 2'd1] == cflr_pkg::CH_XL ||
			     info.hex_text[i[1:0] + 2'd1] == cflr_pkg::CH_XU)) begin
				i = i + 3'd2;
			end
		end
		for (int k = 0; k < 4; k++) begin
			hv = cflr_pkg::hex_val(info.hex_text[k]);
			if (i == 3'(k) && hv[4]) begin
				v = {v[11:0], hv[3:0]};
				i = 3'(k + 1);
			end
		end
		hex_value = neg ? (~v + 16'd1) : v;
	end

	assign count_ext = 32'(payload_count);
	assign hex_short = cut ? (info.hex_count < 3'd4) : !info.hex_ok;

	// Checks in priority order.
	always_comb begin
		if (capacity < cflr_pkg::CAP_MIN) begin
			status = cflr_pkg::ST_OVERFLOW;
		end else if (timeout) begin
			status = cflr_pkg::ST_TIMEOUT;
		end else if (!cut && line_count == pending_cr) begin
			status = cflr_pkg::ST_TIMEOUT;
		end else if (info.phase != cflr_pkg::PH_HEX) begin
			status = cflr_pkg::ST_FORMAT;
		end else if (count_ext != info.len_acc) begin
			status = cflr_pkg::ST_LENGTH;
		end else if (hex_short) begin
			status = cflr_pkg::ST_FORMAT;
		end else if (hex_value != info.crc) begin
			status = cflr_pkg::ST_CRC;
		end else if ((count_ext + 32'd1) > 32'(capacity)) begin
			status = cflr_pkg::ST_OVERFLOW;
		end else begin
			status = cflr_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/cflr_core.sv
// Line parser: holds the per-line state and works through one word per step,
// giving at most one result word. Depends on cflr_pkg and cflr_judge.
`default_nettype none

module cflr_core #(
	parameter int LINE_MAX = 1024,
	localparam int LC_W = $clog2(LINE_MAX)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire cflr_pkg::in_word_t  item,
	input  wire logic [10:0]         capacity,
	output logic                     has_res,
	output cflr_pkg::out_word_t      res
);

	cflr_pkg::phase_t phase_q, phase_d;
	logic [15:0]      crc_q, crc_d;
	logic [31:0]      seq_q, seq_d;
	logic [7:0]       chan_q, chan_d;
	logic [31:0]      len_q, len_d;
	logic [32:0]      num_q, num_d;
	logic [1:0]       sub_q, sub_d;
	logic             neg_q, neg_d;
	logic             dig_q, dig_d;
	logic [LC_W-1:0]  pcount_q, pcount_d;
	logic [LC_W-1:0]  lcount_q, lcount_d;
	logic [LC_W-1:0]  pcr_q, pcr_d;
	logic [3:0][7:0]  hex_text_q, hex_text_d;
	logic [2:0]       hex_count_q, hex_count_d;
	logic             hex_ok_q, hex_ok_d;

	logic [7:0]             c;
	logic                   is_tmo;
	logic                   is_lf;
	logic                   line_full;
	logic                   verdict;
	logic [2:0]             status;
	logic [31:0]            field_val;
	logic [31:0]            count_ext;
	cflr_pkg::frame_info_t  info;

	assign c         = item.rx_byte;
	assign is_tmo    = (item.mode == cflr_pkg::MODE_TIMEOUT);
	assign is_lf     = (c == cflr_pkg::CH_LF);
	assign line_full = ({1'b0, lcount_q} + 1'b1) >= (LC_W + 1)'(LINE_MAX);
	assign verdict   = is_tmo || is_lf || line_full;
	assign count_ext = 32'(pcount_q);

	// Value of a finished decimal field.
	assign field_val = num_q[32] ? 32'hFFFF_FFFF :
	                   (neg_q ? (~num_q[31:0] + 32'd1) : num_q[31:0]);

	assign info = '{phase: phase_q, len_acc: len_q, crc: crc_q, hex_text: hex_text_q,
	                hex_count: hex_count_q, hex_ok: hex_ok_q};

	cflr_judge #(.LINE_MAX(LINE_MAX)) u_judge (
		.capacity      (capacity),
		.timeout       (is_tmo),
		.cut           (!is_tmo && !is_lf && line_full),
		.info          (info),
		.line_count    (lcount_q),
		.pending_cr    (pcr_q),
		.payload_count (pcount_q),
		.status        (status)
	);

	// Next state and result for the word in hand.
	always_comb begin
		phase_d     = phase_q;
		crc_d       = crc_q;
		seq_d       = seq_q;
		chan_d      = chan_q;
		len_d       = len_q;
		num_d       = num_q;
		sub_d       = sub_q;
		neg_d       = neg_q;
		dig_d       = dig_q;
		pcount_d    = pcount_q;
		lcount_d    = lcount_q;
		pcr_d       = pcr_q;
		hex_text_d  = hex_text_q;
		hex_count_d = hex_count_q;
		hex_ok_d    = hex_ok_q;
		has_res     = 1'b0;
		res         = '0;

		if (verdict) begin
			// End of line, timeout or full line: report and start over.
			has_res  = 1'b1;
			res.kind = cflr_pkg::KIND_VERDICT;
			res.status = status;
			if (status == cflr_pkg::ST_OK) begin
				res.sequence_res   = seq_q;
				res.channel        = chan_q;
				res.payload_length = count_ext[9:0];
			end
			phase_d     = cflr_pkg::PH_LEAD;
			crc_d       = cflr_pkg::CRC_INIT;
			seq_d       = '0;
			chan_d      = '0;
			len_d       = '0;
			num_d       = '0;
			sub_d       = cflr_pkg::SUB_START;
			neg_d       = 1'b0;
			dig_d       = 1'b0;
			pcount_d    = '0;
			lcount_d    = '0;
			pcr_d       = '0;
			hex_text_d  = '0;
			hex_count_d = '0;
			hex_ok_d    = 1'b0;
		end else begin
			lcount_d = lcount_q + 1'b1;
			pcr_d    = (c == cflr_pkg::CH_CR) ? (pcr_q + 1'b1) : '0;
			case (phase_q)
				cflr_pkg::PH_LEAD: begin
					if (c == cflr_pkg::CH_AT) begin
						phase_d = cflr_pkg::PH_SEQ;
					end else if (!cflr_pkg::is_ws(c)) begin
						phase_d = cflr_pkg::PH_ERR;
					end
				end
				cflr_pkg::PH_SEQ, cflr_pkg::PH_CHAN, cflr_pkg::PH_LEN: begin
					if (c == cflr_pkg::CH_NUL) begin
						phase_d = cflr_pkg::PH_ERR;
					end else if (c == cflr_pkg::CH_COMMA) begin
						// Close the field and store it.
						if (!dig_q) begin
							phase_d = cflr_pkg::PH_ERR;
						end else begin
							num_d = '0;
							sub_d = cflr_pkg::SUB_START;
							neg_d = 1'b0;
							dig_d = 1'b0;
							if (phase_q == cflr_pkg::PH_SEQ) begin
								seq_d   = field_val;
								phase_d = cflr_pkg::PH_CHAN;
							end else if (phase_q == cflr_pkg::PH_CHAN) begin
								if (field_val[31:8] != 24'd0) begin
									phase_d = cflr_pkg::PH_ERR;
								end else begin
									chan_d  = field_val[7:0];
									phase_d = cflr_pkg::PH_LEN;
								end
							end else begin
								len_d   = field_val;
								phase_d = cflr_pkg::PH_PAYLOAD;
							end
						end
					end else begin
						// Feed one character to the decimal field.
						if (sub_q == cflr_pkg::SUB_START && cflr_pkg::is_ws(c)) begin
							sub_d = sub_q;
						end else if (sub_q == cflr_pkg::SUB_START &&
						             (c == cflr_pkg::CH_PLUS || c == cflr_pkg::CH_MINUS)) begin
							sub_d = cflr_pkg::SUB_SIGN;
							neg_d = neg_q || (c == cflr_pkg::CH_MINUS);
						end else if (sub_q == cflr_pkg::SUB_DONE) begin
							sub_d = sub_q;
						end else if (cflr_pkg::is_digit(c)) begin
							num_d = cflr_pkg::num_step(num_q, c[3:0]);
							sub_d = cflr_pkg::SUB_DIGIT;
							dig_d = 1'b1;
						end else begin
							sub_d = cflr_pkg::SUB_DONE;
						end
					end
				end
				cflr_pkg::PH_PAYLOAD: begin
					if (c == cflr_pkg::CH_NUL) begin
						phase_d = cflr_pkg::PH_ERR;
					end else if (c == cflr_pkg::CH_STAR) begin
						phase_d     = cflr_pkg::PH_HEX;
						hex_count_d = '0;
					end else begin
						crc_d            = cflr_pkg::crc_byte(crc_q, c);
						pcount_d         = pcount_q + 1'b1;
						has_res          = 1'b1;
						res.kind         = cflr_pkg::KIND_PAYLOAD;
						res.payload_byte = c;
					end
				end
				cflr_pkg::PH_HEX: begin
					if (c != cflr_pkg::CH_CR && hex_count_q >= 3'd3) begin
						hex_ok_d = 1'b1;
					end
					if (hex_count_q < 3'd4) begin
						if (c == cflr_pkg::CH_NUL) begin
							phase_d = cflr_pkg::PH_ERR;
						end else begin
							hex_text_d[hex_count_q[1:0]] = c;
							hex_count_d = hex_count_q + 3'd1;
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Line state registers, advanced once per consumed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cflr_pkg::PH_LEAD;
			crc_q       <= cflr_pkg::CRC_INIT;
			seq_q       <= '0;
			chan_q      <= '0;
			len_q       <= '0;
			num_q       <= '0;
			sub_q       <= cflr_pkg::SUB_START;
			neg_q       <= 1'b0;
			dig_q       <= 1'b0;
			pcount_q    <= '0;
			lcount_q    <= '0;
			pcr_q       <= '0;
			hex_text_q  <= '0;
			hex_count_q <= '0;
			hex_ok_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			crc_q       <= crc_d;
			seq_q       <= seq_d;
			chan_q      <= chan_d;
			len_q       <= len_d;
			num_q       <= num_d;
			sub_q       <= sub_d;
			neg_q       <= neg_d;
			dig_q       <= dig_d;
			pcount_q    <= pcount_d;
			lcount_q    <= lcount_d;
			pcr_q       <= pcr_d;
			hex_text_q  <= hex_text_d;
			hex_count_q <= hex_count_d;
			hex_ok_q    <= hex_ok_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/crc_framed_line_receiver.sv
// Top level of the framed line receiver: input register, line parser, result
// register and the capacity register. Depends on cflr_pkg and cflr_core.
//
//  channel  | signals                       | moves
//  ---------+-------------------------------+------------------------------------
//  item     | item_valid, item_ready, item  | one received byte or timeout event
//  res      | res_valid, res_ready, res     | one payload byte or frame verdict
//  cfg      | cfg_we, cfg_wdata             | payload capacity, written at once
//
// Each word is parsed in the input register; its result, if any, goes into
// the result register as the word moves on, so a word can be taken every
// cycle unless the input register is held. The input register holds a word
// only while it would produce a result and the result register is full and
// not being taken. Reset clears the line state and sets the capacity to 1024.
`default_nettype none

module crc_framed_line_receiver #(
	parameter int LINE_MAX = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire cflr_pkg::in_word_t  item,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output cflr_pkg::out_word_t      res,
	input  wire logic                cfg_we,
	input  wire logic [10:0]         cfg_wdata
);

	cflr_pkg::in_word_t  item_s1;
	logic                v_s1;
	cflr_pkg::out_word_t res_s2;
	logic                res_v_s2;
	logic [10:0]         cap_q;
	logic                has_res;
	cflr_pkg::out_word_t core_res;
	logic                advance;

	// The parsed word moves on unless its result would overwrite a waiting one.
	assign advance    = v_s1 && (!has_res || !res_v_s2 || res_ready);
	assign item_ready = !v_s1 || advance;
	assign res_valid  = res_v_s2;
	assign res        = res_s2;

	cflr_core #(.LINE_MAX(LINE_MAX)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.capacity (cap_q),
		.has_res  (has_res),
		.res      (core_res)
	);

	// Input register valid and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			cap_q <= cflr_pkg::CAP_RESET;
		end else begin
			if (item_ready) begin
				v_s1 <= item_valid;
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (advance && has_res) begin
			res_v_s2 <= 1'b1;
		end else if (res_ready) begin
			res_v_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_s2 <= core_res;
		end
	end

endmodule

`default_nettype wire
